### src/tdbcg_pkg.sv
// shared types and constants for the two-digit blink code generator
// no dependencies; imported by tdbcg_core, tdbcg_out_reg and the top level
`timescale 1ns / 1ps
`default_nettype none

package tdbcg_pkg;

	localparam int unsigned CODE_W     = 8;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned INTERVAL_W = 24;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned TALLY_W    = 5;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd2500;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_CODE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_INTERVAL = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0]     blink_code;
		logic [INTERVAL_W-1:0] toggle_interval;
	} cfg_t;

	typedef struct packed {
		logic on_high_digit;
		logic blink_active;
		logic led_on;
	} result_t;

endpackage

`default_nettype wire

### src/tdbcg_core.sv
// blink state registers and the single-pass next-state logic
// depends on tdbcg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdbcg_core
	import tdbcg_pkg::*;
#(
	parameter int unsigned GAP_FACTOR = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [TIME_W-1:0] now_time,
	input  wire cfg_t              cfg,
	output result_t                res
);

	localparam int unsigned GAP_W = TIME_W + 1;

	logic [TIME_W-1:0]  stamp_q;
	logic [TALLY_W-1:0] tally_q;
	logic               phase_q;

	logic [TIME_W-1:0]  stamp_d;
	logic [TALLY_W-1:0] tally_d;
	logic               phase_d;

	logic [DIGIT_W-1:0] lo_digit;
	logic [DIGIT_W-1:0] hi_digit;
	logic [DIGIT_W-1:0] digit;
	logic               phase_sel;
	logic               in_digit;
	logic [GAP_W-1:0]   gap_wide;
	logic [TIME_W-1:0]  span;
	logic [TIME_W-1:0]  delta;
	logic               hit;
	logic               code_zero;

	always_comb begin
		lo_digit  = cfg.blink_code[DIGIT_W-1:0];
		hi_digit  = cfg.blink_code[CODE_W-1:DIGIT_W];
		code_zero = (cfg.blink_code == '0);

		// single digit forces the phase
		if (lo_digit != '0 && hi_digit != '0) begin
			phase_sel = phase_q;
		end else if (lo_digit != '0) begin
			phase_sel = 1'b0;
		end else begin
			phase_sel = 1'b1;
		end

		digit    = phase_sel ? hi_digit : lo_digit;
		in_digit = (tally_q[TALLY_W-1:1] < digit);

		// gap after the high digit is twice as long
		gap_wide = (GAP_W'(cfg.toggle_interval) * GAP_W'(GAP_FACTOR)) << phase_sel;
		if (in_digit) begin
			span = TIME_W'(cfg.toggle_interval);
		end else if (gap_wide[GAP_W-1]) begin
			span = '1;
		end else begin
			span = gap_wide[TIME_W-1:0];
		end

		delta = now_time - stamp_q;
		hit   = (delta >= span);

		stamp_d = stamp_q;
		tally_d = tally_q;
		phase_d = phase_q;
		if (!code_zero) begin
			phase_d = phase_sel;
			if (hit) begin
				stamp_d = now_time;
			end
			if (in_digit) begin
				if (hit) begin
					tally_d = tally_q + TALLY_W'(1);
				end
			end else if (hit) begin
				tally_d = '0;
				phase_d = !phase_sel;
			end
		end

		res.led_on        = !code_zero && !tally_d[0];
		res.blink_active  = !code_zero;
		res.on_high_digit = !code_zero && phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= '0;
			tally_q <= '0;
			phase_q <= 1'b0;
		end else if (step) begin
			stamp_q <= stamp_d;
			tally_q <= tally_d;
			phase_q <= phase_d;
		end
	end

`ifndef NO_ASSERTIONS
	// a digit never needs more than thirty toggles
	a_tally_range: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_W'(30))
		else $error("toggle tally out of range");

	// a zero code freezes all state
	a_zero_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && code_zero) |=> ($stable(tally_q) && $stable(phase_q) && $stable(stamp_q)))
		else $error("state moved while code is zero");

	// state only moves on a step
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(tally_q) && $stable(phase_q) && $stable(stamp_q)))
		else $error("state moved without a step");

	// a toggle always restarts the stamp at the sample time
	a_stamp_on_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && tally_d != tally_q) |=> (stamp_q == $past(now_time)))
		else $error("tally moved without restarting the stamp");
`endif

endmodule

`default_nettype wire

### src/tdbcg_out_reg.sv
// result register on the master side of the stream
// depends on tdbcg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdbcg_out_reg
	import tdbcg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire result_t               res,
	output logic                       space,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic    valid_q;
	result_t res_q;

	// register is free when empty or when its beat leaves this cycle
	assign space    = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_DATA_W-3){1'b0}}, res_q.on_high_digit, res_q.blink_active,
		res_q.led_on};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && space) begin
			res_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	// loads only arrive when there is room
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> space)
		else $error("result loaded into a full register");

	// an inactive result carries no lamp or digit
	a_inactive_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !res_q.blink_active) |-> (!res_q.led_on && !res_q.on_high_digit))
		else $error("inactive result with lamp or digit set");

	// a loaded result is shown next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

### src/two_digit_blink_code_generator.sv
// top level of the two-digit blink code generator: input stage, core, result register
// depends on tdbcg_pkg, tdbcg_core and tdbcg_out_reg
`timescale 1ns / 1ps
`default_nettype none

// Two-digit blink code generator for an error LED.
// Slave stream: each beat carries the current free-running time (s_tdata[31:0]).
// Master stream: one result beat per input beat, in order; m_tdata bit 0 led_on,
//   bit 1 blink_active, bit 2 on_high_digit, bits 7:3 zero.
// Configuration channel: cfg_index 0 writes blink_code (cfg_data[7:0]), index 1
//   writes toggle_interval (cfg_data[23:0]); cfg_ready is always high. Write it
//   only while no beat is in flight.
// Pipeline: an accepted beat is registered in the input stage; once the result
//   register has room, its blink state is updated and its result is loaded into
//   the result register, which then drives m_tvalid until the beat leaves.
// Throughput: one beat per cycle while the receiver does not stall; the state
//   update is a combinational 32-bit subtract and compare plus small counter logic.
// Reset (arst_n low, asynchronous): both stages empty, blink code 0, toggle
//   interval 2500, time stamp, toggle count and digit phase zero.
// Receiver stall: the result register holds its beat, the input stage fills,
//   then s_tready drops; no beat is lost or repeated.
module two_digit_blink_code_generator
	import tdbcg_pkg::*;
#(
	parameter int unsigned GAP_FACTOR = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// slave stream: [31:0] now_time
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [TIME_W-1:0]     s_tdata,
	// master stream: [0] led_on, [1] blink_active, [2] on_high_digit, [7:3] zero
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic              out_space;
	logic              step;
	result_t           res;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_code      <= '0;
			cfg_q.toggle_interval <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLINK_CODE: begin
					cfg_q.blink_code <= cfg_data[CODE_W-1:0];
				end
				REG_TOGGLE_INTERVAL: begin
					cfg_q.toggle_interval <= cfg_data[INTERVAL_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input stage: the beat in it is processed once the result register has room
	assign step     = valid_s1 && out_space;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1 <= s_tdata;
		end
	end

	tdbcg_core #(
		.GAP_FACTOR (GAP_FACTOR)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.now_time (now_s1),
		.cfg      (cfg_q),
		.res      (res)
	);

	tdbcg_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.space    (out_space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef NO_ASSERTIONS
	// an accepted beat always reaches the input stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted beat not captured");

	// the input stage only stalls behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a downstream stall");

	// padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:3] == '0))
		else $error("nonzero padding in result beat");
`endif

endmodule

`default_nettype wire
